### rtl/vit_pkg.sv
// ----------------------------------------------------------------------------
// vit_pkg
// Shared constants and types for the K=3, rate-1/2 hard-decision decoder.
// ----------------------------------------------------------------------------
package vit_pkg;

    // Trellis geometry
    localparam int MAX_STAGES = 64;
    localparam int NUM_STATES = 4;
    localparam int ADDR_W     = $clog2(MAX_STAGES);
    localparam int CNT_W      = $clog2(MAX_STAGES + 1);
    localparam int METRIC_W   = 8;
    localparam int STATE_W    = 2;

    // Configuration register map (word index)
    localparam logic REG_TERMINATED = 1'b0;

    // One add-compare-select request: the two predecessors of a state
    typedef struct packed {
        logic [METRIC_W-1:0] pm_a;     // predecessor with D2 = 0
        logic [METRIC_W-1:0] pm_b;     // predecessor with D2 = 1
        logic                reach_a;
        logic                reach_b;
        logic                u;        // input bit leading into the state
        logic                hi;       // D1 of the predecessors
        logic                rx0;      // received first bit
        logic                rx1;      // received second bit
    } t_acs_req;

    // Outcome of one add-compare-select step
    typedef struct packed {
        logic [METRIC_W-1:0] best;
        logic                dec;
        logic                found;
    } t_acs_res;

endpackage

### rtl/vit_ram.sv
// ----------------------------------------------------------------------------
// vit_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module vit_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/vit_acs.sv
// ----------------------------------------------------------------------------
// vit_acs
// Shared add-compare-select unit: Hamming branch metrics for both
// predecessors of one state, then pick the smaller (D2 = 0 wins ties).
// ----------------------------------------------------------------------------
module vit_acs (
    input  vit_pkg::t_acs_req i_req,
    output vit_pkg::t_acs_res o_res
);

    logic [1:0]                  bm_a;
    logic [1:0]                  bm_b;
    logic [vit_pkg::METRIC_W:0]  cand_a;
    logic [vit_pkg::METRIC_W:0]  cand_b;
    logic                        g0_a;
    logic                        g1_a;

    // Branch metrics: predecessor D2=0 emits (u, u^hi), D2=1 the complement
    assign g0_a   = i_req.u;
    assign g1_a   = i_req.u ^ i_req.hi;
    assign bm_a   = {1'b0, g0_a ^ i_req.rx0} + {1'b0, g1_a ^ i_req.rx1};
    assign bm_b   = {1'b0, ~g0_a ^ i_req.rx0} + {1'b0, ~g1_a ^ i_req.rx1};
    assign cand_a = {1'b0, i_req.pm_a} + {{(vit_pkg::METRIC_W-1){1'b0}}, bm_a};
    assign cand_b = {1'b0, i_req.pm_b} + {{(vit_pkg::METRIC_W-1){1'b0}}, bm_b};

    // Compare-select; unreachable predecessors never compete
    always_comb begin
        o_res = '0;
        priority if (i_req.reach_a && (!i_req.reach_b || cand_a <= cand_b)) begin
            o_res.best  = cand_a[vit_pkg::METRIC_W-1:0];
            o_res.dec   = 1'b0;
            o_res.found = 1'b1;
        end else if (i_req.reach_b) begin
            o_res.best  = cand_b[vit_pkg::METRIC_W-1:0];
            o_res.dec   = 1'b1;
            o_res.found = 1'b1;
        end else begin
            o_res = '0;
        end
    end

endmodule

### rtl/viterbi_decoder_k3_rate_half.sv
// ----------------------------------------------------------------------------
// viterbi_decoder_k3_rate_half
// Hard-decision Viterbi decoder, K=3, rate 1/2, generators 5 and 7 (octal).
// ----------------------------------------------------------------------------
// A pair is taken when start is high and busy is low. One add-compare-select
// unit visits the four states in turn, and busy stays high until all four are
// done, so a new pair is taken only once the last one is through. On the pair
// marked block_end (or the 64th pair) the block then chooses the start state,
// traces back stage by stage (one survivor RAM read each), and then streams
// one result per cycle, oldest stage first, on o_strobe. The results of a
// block come on consecutive cycles and cannot be held off; o_run_end marks
// the last one.
// ----------------------------------------------------------------------------
module viterbi_decoder_k3_rate_half (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Command interface
    input  logic        start,
    output logic        busy,
    input  logic        i_coded_first,
    input  logic        i_coded_second,
    input  logic        i_block_end,
    // Result interface
    output logic        o_strobe,
    output logic        o_decoded_bit,
    output logic        o_fixed_first,
    output logic        o_fixed_second,
    output logic [7:0]  o_final_metric,
    output logic        o_run_end,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ACS   = 3'd1;
    localparam logic [2:0] S_PICK  = 3'd2;
    localparam logic [2:0] S_TB_RD = 3'd3;
    localparam logic [2:0] S_TB_WR = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    localparam int AW = vit_pkg::ADDR_W;
    localparam int CW = vit_pkg::CNT_W;
    localparam int MW = vit_pkg::METRIC_W;
    localparam int NS = vit_pkg::NUM_STATES;

    logic [2:0]                      r_state;
    logic                            r_term;
    logic                            r_rx0;
    logic                            r_rx1;
    logic                            r_end;
    logic [vit_pkg::STATE_W-1:0]     r_d;
    logic [MW-1:0]                   r_pm     [NS];
    logic [MW-1:0]                   r_pm_new [NS];
    logic [NS-1:0]                   r_reach;
    logic [NS-1:0]                   r_reach_new;
    logic [NS-1:0]                   r_dec;
    logic [CW-1:0]                   r_cnt;
    logic [CW-1:0]                   r_k;
    logic [vit_pkg::STATE_W-1:0]     r_s;
    logic                            r_have;
    logic [MW-1:0]                   r_best;
    logic [MW-1:0]                   r_metric;
    logic                            r_vld;
    logic                            r_last;

    vit_pkg::t_acs_req               acs_req;
    vit_pkg::t_acs_res               acs_res;
    logic                            accept;
    logic                            cfg_wr;
    logic                            surv_we;
    logic [NS-1:0]                   surv_wdata;
    logic [NS-1:0]                   surv_q;
    logic [AW-1:0]                   surv_raddr;
    logic                            res_we;
    logic [2:0]                      res_wdata;
    logic [2:0]                      res_q;
    logic [AW-1:0]                   res_addr_tb;
    logic [MW-1:0]                   pick_pm;
    logic                            pick_take;
    logic                            tb_dec;
    logic                            tb_u;
    logic                            tb_hi;
    logic                            emit_last;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == vit_pkg::REG_TERMINATED);
    assign prdata = (paddr[2] == vit_pkg::REG_TERMINATED) ? {31'd0, r_term} : 32'd0;

    // Shared add-compare-select unit: predecessors of state d are {0,hi} and {1,hi}
    always_comb begin
        acs_req.pm_a    = r_pm[{1'b0, r_d[1]}];
        acs_req.pm_b    = r_pm[{1'b1, r_d[1]}];
        acs_req.reach_a = r_reach[{1'b0, r_d[1]}];
        acs_req.reach_b = r_reach[{1'b1, r_d[1]}];
        acs_req.u       = r_d[0];
        acs_req.hi      = r_d[1];
        acs_req.rx0     = r_rx0;
        acs_req.rx1     = r_rx1;
    end

    vit_acs u_acs (
        .i_req (acs_req),
        .o_res (acs_res)
    );

    // Survivor store: one decision word per stage
    assign surv_we    = (r_state == S_ACS) && (r_d == 2'd3);
    assign surv_wdata = {acs_res.dec, r_dec[2:0]};
    assign surv_raddr = AW'(r_k - CW'(1));

    vit_ram #(
        .WIDTH (NS),
        .DEPTH (vit_pkg::MAX_STAGES)
    ) u_surv_ram (
        .i_clk     (i_clk),
        .i_wr_en   (surv_we),
        .i_wr_addr (r_cnt[AW-1:0]),
        .i_wr_data (surv_wdata),
        .i_rd_addr (surv_raddr),
        .o_rd_data (surv_q)
    );

    // Traceback step: decision of the current state gives the predecessor
    assign tb_dec      = surv_q[r_s];
    assign tb_u        = r_s[0];
    assign tb_hi       = r_s[1];
    assign res_we      = (r_state == S_TB_WR);
    assign res_wdata   = {tb_u, tb_u ^ tb_dec, tb_u ^ tb_hi ^ tb_dec};
    assign res_addr_tb = AW'(r_k - CW'(1));

    // Result store, written newest first, read oldest first
    vit_ram #(
        .WIDTH (3),
        .DEPTH (vit_pkg::MAX_STAGES)
    ) u_res_ram (
        .i_clk     (i_clk),
        .i_wr_en   (res_we),
        .i_wr_addr (res_addr_tb),
        .i_wr_data (res_wdata),
        .i_rd_addr (r_k[AW-1:0]),
        .o_rd_data (res_q)
    );

    // Start-state search over the reachable states
    assign pick_pm   = r_pm[r_d];
    assign pick_take = r_reach[r_d] && (!r_have || pick_pm < r_best);
    assign emit_last = (r_k == r_cnt - CW'(1));

    // Sequencer and trellis state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_term  <= 1'b1;
            r_reach <= NS'(1);
            r_cnt   <= '0;
            r_vld   <= 1'b0;
            r_last  <= 1'b0;
            for (int i = 0; i < NS; i++) begin
                r_pm[i] <= '0;
            end
        end else begin
            if (cfg_wr) begin
                r_term <= pwdata[0];
            end
            // Result strobe follows the emit cycle that fetched the stage
            r_vld  <= (r_state == S_EMIT);
            r_last <= (r_state == S_EMIT) && emit_last;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_rx0   <= i_coded_first;
                        r_rx1   <= i_coded_second;
                        r_end   <= i_block_end;
                        r_d     <= '0;
                        r_state <= S_ACS;
                    end
                end
                S_ACS: begin
                    r_pm_new[r_d]    <= acs_res.best;
                    r_reach_new[r_d] <= acs_res.found;
                    r_dec[r_d]       <= acs_res.dec;
                    r_d              <= r_d + 2'd1;
                    if (r_d == 2'd3) begin
                        // Commit the new stage
                        for (int i = 0; i < NS - 1; i++) begin
                            r_pm[i] <= r_pm_new[i];
                        end
                        r_pm[NS-1] <= acs_res.best;
                        r_reach    <= {acs_res.found, r_reach_new[2:0]};
                        r_cnt      <= r_cnt + CW'(1);
                        r_have     <= 1'b0;
                        r_s        <= '0;
                        if (r_end || r_cnt == CW'(vit_pkg::MAX_STAGES - 1)) begin
                            r_state <= S_PICK;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_PICK: begin
                    r_d <= r_d + 2'd1;
                    if (r_d == 2'd3) begin
                        r_k     <= r_cnt;
                        r_state <= S_TB_RD;
                        if (r_term) begin
                            r_s      <= '0;
                            r_metric <= r_pm[0];
                        end else begin
                            r_s      <= pick_take ? r_d : r_s;
                            r_metric <= pick_take ? pick_pm : r_best;
                        end
                    end else if (pick_take) begin
                        r_best <= pick_pm;
                        r_s    <= r_d;
                        r_have <= 1'b1;
                    end
                end
                S_TB_RD: begin
                    r_state <= S_TB_WR;
                end
                S_TB_WR: begin
                    r_s <= {tb_dec, tb_hi};
                    r_k <= r_k - CW'(1);
                    if (r_k == CW'(1)) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_TB_RD;
                    end
                end
                S_EMIT: begin
                    r_k <= r_k + CW'(1);
                    if (emit_last) begin
                        // Back to the reset trellis
                        r_reach <= NS'(1);
                        r_cnt   <= '0;
                        for (int i = 0; i < NS; i++) begin
                            r_pm[i] <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Result ports
    assign o_strobe       = r_vld;
    assign o_decoded_bit  = res_q[2];
    assign o_fixed_first  = res_q[1];
    assign o_fixed_second = res_q[0];
    assign o_final_metric = r_metric;
    assign o_run_end      = r_last;

endmodule

### rtl/vit_chk.sv
// ----------------------------------------------------------------------------
// vit_chk
// Port-level checks for the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module vit_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_strobe,
    input logic [7:0] o_final_metric,
    input logic       o_run_end
);

    // An accepted pair always occupies the block for the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy low right after a transfer");

    // The last-result mark only comes with a result
    a_end_has_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_run_end |-> o_strobe)
        else $error("run_end without strobe");

    // Results of a block are back to back until the last one
    a_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_run_end) |=> o_strobe)
        else $error("gap inside a block of results");

    // One metric per block
    a_metric_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_run_end) |=> $stable(o_final_metric))
        else $error("final_metric changed inside a block");

    // Nothing follows the last result directly
    a_quiet_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_run_end |=> !o_strobe)
        else $error("strobe right after run_end");

endmodule

bind viterbi_decoder_k3_rate_half vit_chk u_vit_chk (.*);

### tb/viterbi_decoder_k3_rate_half_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// viterbi_decoder_k3_rate_half_checker
// Watches the pair, result and register ports of the decoder, runs its own
// trellis (branch metrics, add-compare-select, traceback) on every accepted
// pair, and compares each decoded stage against the oldest prediction.
// ----------------------------------------------------------------------------
module viterbi_decoder_k3_rate_half_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Pair transfers
    input  logic        start,
    input  logic        busy,
    input  logic        i_coded_first,
    input  logic        i_coded_second,
    input  logic        i_block_end,
    // Decoded stages
    input  logic        o_strobe,
    input  logic        o_decoded_bit,
    input  logic        o_fixed_first,
    input  logic        o_fixed_second,
    input  logic [7:0]  o_final_metric,
    input  logic        o_run_end,
    // Register writes
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    // To the test top
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic                         decoded_bit;
        logic                         fixed_first;
        logic                         fixed_second;
        logic [vit_pkg::METRIC_W-1:0] final_metric;
        logic                         run_end;
    } t_stage_result;

    // Local copy of the trellis
    logic [vit_pkg::METRIC_W-1:0]   metric_q [vit_pkg::NUM_STATES];
    logic [vit_pkg::NUM_STATES-1:0] live_states;
    logic [vit_pkg::NUM_STATES-1:0] branch_sel [vit_pkg::MAX_STAGES];
    int                             stage_total;
    logic                           zero_start;
    t_stage_result                  decoded_q [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: decoded stage mismatch on %s: got %0d, expected %0d",
                 $realtime, what, got, want);
        o_fail_count++;
    endtask

    task automatic check_field(input string what, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_mismatch(what, int'(got), int'(want));
    endtask

    function automatic void restart_trellis();
        foreach (metric_q[i])
            metric_q[i] = '0;
        live_states = 4'b0001;
        stage_total = 0;
    endfunction

    // One trellis stage; on the last pair of a block, trace back and queue
    // the decoded stages oldest first.
    task automatic decode_pair(input logic rx0, input logic rx1, input logic last);
        logic [vit_pkg::METRIC_W-1:0]   pm_n [vit_pkg::NUM_STATES];
        logic [vit_pkg::NUM_STATES-1:0] reach_n;
        logic [vit_pkg::NUM_STATES-1:0] dec_n;
        t_stage_result                  path [vit_pkg::MAX_STAGES];
        logic                           hi, u, dec, found, have, g0, g1;
        logic [vit_pkg::METRIC_W-1:0]   end_metric;
        int                             d, old, src, cand, best, s, k;

        reach_n = '0;
        dec_n   = '0;
        for (d = 0; d < vit_pkg::NUM_STATES; d++) begin
            hi    = d[1];
            u     = d[0];
            found = 1'b0;
            best  = 0;
            dec   = 1'b0;
            // lower-index predecessor is tried first and keeps ties
            for (old = 0; old < 2; old++) begin
                src = old * 2 + int'(hi);
                if (live_states[src]) begin
                    g0   = u ^ old[0];
                    g1   = u ^ hi ^ old[0];
                    cand = int'(metric_q[src]) + int'(g0 ^ rx0) + int'(g1 ^ rx1);
                    if (!found || cand < best) begin
                        best  = cand;
                        dec   = old[0];
                        found = 1'b1;
                    end
                end
            end
            pm_n[d]    = found ? best[vit_pkg::METRIC_W-1:0] : '0;
            reach_n[d] = found;
            dec_n[d]   = dec;
        end
        metric_q    = pm_n;
        live_states = reach_n;
        if (stage_total < vit_pkg::MAX_STAGES) begin
            branch_sel[stage_total] = dec_n;
            stage_total++;
        end

        if (last || stage_total >= vit_pkg::MAX_STAGES) begin
            // traceback start: state zero, or least metric (lowest index on tie)
            s    = 0;
            have = 1'b0;
            if (!zero_start) begin
                for (d = 0; d < vit_pkg::NUM_STATES; d++) begin
                    if (live_states[d] && (!have || metric_q[d] < metric_q[s])) begin
                        s    = d;
                        have = 1'b1;
                    end
                end
            end
            end_metric = metric_q[s];
            for (k = stage_total; k > 0; k--) begin
                dec = branch_sel[k-1][s];
                u   = s[0];
                hi  = s[1];
                path[k-1].decoded_bit  = u;
                path[k-1].fixed_first  = u ^ dec;
                path[k-1].fixed_second = u ^ hi ^ dec;
                path[k-1].final_metric = end_metric;
                path[k-1].run_end      = (k == stage_total);
                s = int'(dec) * 2 + int'(hi);
            end
            for (k = 0; k < stage_total; k++)
                decoded_q.push_back(path[k]);
            restart_trellis();
        end
    endtask

    // Transfers are sampled at the clock edge that completes them
    always @(posedge i_clk) begin
        t_stage_result want;
        if (!i_rst_n) begin
            restart_trellis();
            foreach (branch_sel[i])
                branch_sel[i] = '0;
            zero_start = 1'b1;
            decoded_q.delete();
        end else begin
            // results first: they belong to blocks already predicted
            if (o_strobe) begin
                if (decoded_q.size() == 0) begin
                    report_mismatch("unexpected result, decoded_bit", int'(o_decoded_bit), -1);
                end else begin
                    want = decoded_q.pop_front();
                    check_field("decoded_bit",  {7'd0, o_decoded_bit},  {7'd0, want.decoded_bit});
                    check_field("fixed_first",  {7'd0, o_fixed_first},  {7'd0, want.fixed_first});
                    check_field("fixed_second", {7'd0, o_fixed_second},
                                {7'd0, want.fixed_second});
                    check_field("final_metric", o_final_metric, want.final_metric);
                    check_field("run_end",      {7'd0, o_run_end},      {7'd0, want.run_end});
                end
            end
            // register write; only word index REG_TERMINATED is mapped
            if (psel && penable && pwrite && pready && (paddr[2] == vit_pkg::REG_TERMINATED))
                zero_start = pwdata[0];
            if (start && !busy)
                decode_pair(i_coded_first, i_coded_second, i_block_end);
        end
        o_pending = decoded_q.size();
    end

endmodule

### tb/viterbi_decoder_k3_rate_half_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// viterbi_decoder_k3_rate_half_test
// Drives coded pairs and register writes into the decoder: a directed opening
// (single-stage blocks, every received pair, both traceback modes, an
// unmapped register), then phases of encoded blocks with random bit errors,
// random noise blocks and full-depth blocks, with bursty pair transfers.
// The checker instance predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module viterbi_decoder_k3_rate_half_test;

    localparam int   ITEM_TARGET   = 300;
    localparam int   CYCLE_LIMIT   = 200000;
    localparam int   SETTLE_CYCLES = 16;
    localparam logic MODE_ZERO_START  = 1'b1;
    localparam logic MODE_BEST_METRIC = 1'b0;
    localparam logic [2:0] ADDR_TERMINATED = {vit_pkg::REG_TERMINATED, 2'b00};
    localparam logic [2:0] ADDR_SPARE      = {~vit_pkg::REG_TERMINATED, 2'b00};

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        start          = 1'b0;
    logic        busy;
    logic        i_coded_first  = 1'b0;
    logic        i_coded_second = 1'b0;
    logic        i_block_end    = 1'b0;
    logic        o_strobe;
    logic        o_decoded_bit;
    logic        o_fixed_first;
    logic        o_fixed_second;
    logic [7:0]  o_final_metric;
    logic        o_run_end;
    logic        psel           = 1'b0;
    logic        penable        = 1'b0;
    logic        pwrite         = 1'b0;
    logic [2:0]  paddr          = '0;
    logic [31:0] pwdata         = '0;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int items       = 0;
    int burst_left  = 0;
    bit steady      = 1'b0;

    viterbi_decoder_k3_rate_half dut (.*);

    viterbi_decoder_k3_rate_half_checker checker_i (
        .i_clk, .i_rst_n, .start, .busy, .i_coded_first, .i_coded_second,
        .i_block_end, .o_strobe, .o_decoded_bit, .o_fixed_first, .o_fixed_second,
        .o_final_metric, .o_run_end, .psel, .penable, .pwrite, .paddr, .pwdata,
        .pready, .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Setup cycle, then access cycle until pready
    task automatic bus_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // One pair transfer; the sender idles between bursts unless steady
    task automatic push_pair(input logic c0, input logic c1, input logic last);
        int gap;
        if (!steady && burst_left == 0) begin
            start <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(1, 10);
        end
        if (burst_left > 0)
            burst_left--;
        start          <= 1'b1;
        i_coded_first  <= c0;
        i_coded_second <= c1;
        i_block_end    <= last;
        do @(posedge i_clk); while (busy);
        items++;
    endtask

    // Hold off until every predicted stage has come out, then let the block settle
    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_mode(input logic mode);
        drain_results();
        bus_write(ADDR_TERMINATED, {31'($urandom()), mode});
    endtask

    // Encoder with generators 5 and 7, optional zero tail and random bit flips
    task automatic send_coded(input int n, input bit tail, input int err_pct,
                              input bit mark_end);
        logic d1, d2, u, c0, c1;
        int   i;
        d1 = 1'b0;
        d2 = 1'b0;
        for (i = 0; i < n; i++) begin
            u  = (tail && i >= n - 2) ? 1'b0 : 1'($urandom());
            c0 = u ^ d2;
            c1 = u ^ d1 ^ d2;
            if ($urandom_range(0, 99) < err_pct)
                c0 = ~c0;
            if ($urandom_range(0, 99) < err_pct)
                c1 = ~c1;
            d2 = d1;
            d1 = u;
            push_pair(c0, c1, mark_end && (i == n - 1));
        end
    endtask

    task automatic send_noise(input int n);
        int i;
        for (i = 0; i < n; i++)
            push_pair(1'($urandom()), 1'($urandom()), i == n - 1);
    endtask

    initial begin
        int phase, kind;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: traceback from state zero
        bus_write(ADDR_TERMINATED, {31'h7fff_ffff, MODE_ZERO_START});
        steady = 1'b1;
        push_pair(1'b1, 1'b1, 1'b1);
        push_pair(1'b0, 1'b0, 1'b1);
        push_pair(1'b0, 1'b0, 1'b0);
        push_pair(1'b0, 1'b1, 1'b0);
        push_pair(1'b1, 1'b0, 1'b0);
        push_pair(1'b1, 1'b1, 1'b1);
        send_coded(6, 1'b1, 0, 1'b1);

        // Directed: least-metric traceback, then a write to an unmapped word
        set_mode(MODE_BEST_METRIC);
        push_pair(1'b0, 1'b1, 1'b1);
        push_pair(1'b1, 1'b0, 1'b0);
        push_pair(1'b1, 1'b1, 1'b0);
        push_pair(1'b0, 1'b1, 1'b0);
        push_pair(1'b0, 1'b0, 1'b1);
        drain_results();
        bus_write(ADDR_SPARE, 32'hffff_ffff);
        send_coded(6, 1'b0, 30, 1'b1);

        // Random phases, each under one traceback mode
        phase = 0;
        while (items < ITEM_TARGET) begin
            set_mode(1'($urandom()));
            steady = ($urandom_range(0, 3) == 0);
            if (phase == 0) begin
                // full store with and without the end mark on the last stage
                send_coded(64, 1'b0, 5, 1'b0);
                send_coded($urandom_range(1, 8), 1'b1, 5, 1'b1);
                send_coded(64, 1'b1, 5, 1'b1);
            end
            repeat ($urandom_range(2, 5)) begin
                kind = $urandom_range(0, 19);
                if (kind < 13)
                    send_coded($urandom_range(1, 16), 1'($urandom()),
                               $urandom_range(0, 15), 1'b1);
                else if (kind < 18)
                    send_noise($urandom_range(1, 12));
                else if (kind == 18) begin
                    send_coded(64, 1'b0, $urandom_range(0, 10), 1'b0);
                    send_noise($urandom_range(1, 4));
                end else
                    send_coded(64, 1'b1, $urandom_range(0, 10), 1'b1);
            end
            phase++;
        end

        drain_results();
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### files.f
rtl/vit_pkg.sv
rtl/vit_ram.sv
rtl/vit_acs.sv
rtl/viterbi_decoder_k3_rate_half.sv
rtl/vit_chk.sv
tb/viterbi_decoder_k3_rate_half_checker.sv
tb/viterbi_decoder_k3_rate_half_test.sv
